// File: src/double_ended_queue_core_macros.svh
// assertion macros for the deque core
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define DQC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque core check failed");

// next-cycle implication, checked outside reset
`define DQC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque core check failed");

`endif

// File: src/dqc_pkg.sv
// shared constants, types and request codes for the deque core
package dqc_pkg;

  localparam int DEPTH       = 1024;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int FUNC_W      = 3;
  localparam int COUNT_OUT_W = 11;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [COUNT_OUT_W-1:0]   count_out_t;

  typedef enum logic [FUNC_W-1:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_t;

  // pointer update request from the sequencer
  typedef struct packed {
    logic valid;
    op_t  op;
  } ptr_cmd_t;

  // pointer status and the ring addresses derived from it
  typedef struct packed {
    cnt_t  count;
    logic  empty;
    logic  full;
    addr_t front_wr_addr;
    addr_t back_wr_addr;
    addr_t front_next_addr;
    addr_t back_next_addr;
  } ptr_stat_t;

endpackage

// File: src/dqc_ram.sv
// generic simple dual-port ram with registered read
module dqc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/dqc_ptr.sv
// head, tail and count registers of the ring store
module dqc_ptr (
  input  logic               clk,
  input  logic               rst,
  input  dqc_pkg::ptr_cmd_t  cmd,
  output dqc_pkg::ptr_stat_t stat
);

  dqc_pkg::addr_t head;
  dqc_pkg::addr_t tail;
  dqc_pkg::cnt_t  count;

  function automatic dqc_pkg::addr_t ring_next(dqc_pkg::addr_t i);
    return (i == dqc_pkg::addr_t'(dqc_pkg::DEPTH - 1)) ? '0 : i + dqc_pkg::addr_t'(1);
  endfunction

  function automatic dqc_pkg::addr_t ring_prev(dqc_pkg::addr_t i);
    return (i == '0) ? dqc_pkg::addr_t'(dqc_pkg::DEPTH - 1) : i - dqc_pkg::addr_t'(1);
  endfunction

  always_comb begin
    stat.count           = count;
    stat.empty           = (count == '0);
    stat.full            = (count == dqc_pkg::cnt_t'(dqc_pkg::DEPTH));
    stat.front_wr_addr   = ring_prev(head);
    stat.back_wr_addr    = tail;
    // new front after a front pop, new back after a back pop
    stat.front_next_addr = ring_next(head);
    stat.back_next_addr  = ring_prev(ring_prev(tail));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.valid) begin
      case (cmd.op)
        dqc_pkg::OP_PUSH_FRONT: begin
          head  <= ring_prev(head);
          count <= count + dqc_pkg::cnt_t'(1);
        end
        dqc_pkg::OP_PUSH_BACK: begin
          tail  <= ring_next(tail);
          count <= count + dqc_pkg::cnt_t'(1);
        end
        dqc_pkg::OP_POP_FRONT: begin
          head  <= ring_next(head);
          count <= count - dqc_pkg::cnt_t'(1);
        end
        dqc_pkg::OP_POP_BACK: begin
          tail  <= ring_prev(tail);
          count <= count - dqc_pkg::cnt_t'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/double_ended_queue_core.sv
// Bounded deque of signed 32-bit words in a 1024-entry ring ram. A request is
// taken when start is high and busy is low; its result appears on the result
// ports with done high for exactly one cycle and must be captured then. The
// front and back words are kept in registers, so queries, pushes and refused
// requests give their result the cycle after the request and a new request
// may be issued every cycle. A pop that leaves entries behind must fetch the
// new end word from the ram, whose read is registered: busy is high for one
// cycle and the result is registered in the fetch state. No clearing pass
// runs after reset; the block is ready as soon as reset is released.
`include "double_ended_queue_core_macros.svh"

module double_ended_queue_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [dqc_pkg::FUNC_W-1:0]               func,
  input  logic signed [dqc_pkg::WORD_W-1:0]        value,
  output logic                                     done,
  output logic signed [dqc_pkg::WORD_W-1:0]        pop_value,
  output logic                                     pop_ok,
  output logic                                     push_dropped,
  output logic [dqc_pkg::COUNT_OUT_W-1:0]          entry_count,
  output logic                                     is_empty,
  output logic signed [dqc_pkg::WORD_W-1:0]        front_value,
  output logic signed [dqc_pkg::WORD_W-1:0]        back_value
);

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_t;

  state_t             state;
  dqc_pkg::ptr_cmd_t  cmd;
  dqc_pkg::ptr_stat_t stat;

  logic                 accept;
  logic                 we;
  dqc_pkg::addr_t       waddr;
  logic                 re;
  dqc_pkg::addr_t       raddr;
  logic [dqc_pkg::WORD_W-1:0] rdata;
  dqc_pkg::word_t       rword;

  dqc_pkg::word_t front_word;
  dqc_pkg::word_t back_word;
  dqc_pkg::word_t front_next;
  dqc_pkg::word_t back_next;
  dqc_pkg::word_t popped;
  dqc_pkg::cnt_t  cnt_after;
  logic           pok;
  logic           dropped;
  logic           fetch;
  logic           fetch_front;

  assign busy   = (state == S_FETCH);
  assign accept = start && !busy;
  assign rword  = dqc_pkg::word_t'(rdata);

  dqc_ptr u_ptr (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  dqc_ram #(
    .WIDTH (dqc_pkg::WORD_W),
    .DEPTH (dqc_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    cmd        = '0;
    we         = 1'b0;
    waddr      = stat.back_wr_addr;
    re         = 1'b0;
    raddr      = stat.front_next_addr;
    cnt_after  = stat.count;
    dropped    = 1'b0;
    popped     = '1;
    pok        = 1'b0;
    fetch      = 1'b0;
    front_next = front_word;
    back_next  = back_word;
    if (accept) begin
      case (func)
        dqc_pkg::OP_PUSH_FRONT: begin
          if (stat.full) begin
            dropped = 1'b1;
          end else begin
            cmd.valid  = 1'b1;
            cmd.op     = dqc_pkg::OP_PUSH_FRONT;
            we         = 1'b1;
            waddr      = stat.front_wr_addr;
            cnt_after  = stat.count + dqc_pkg::cnt_t'(1);
            front_next = value;
            if (stat.empty) begin
              back_next = value;
            end
          end
        end
        dqc_pkg::OP_PUSH_BACK: begin
          if (stat.full) begin
            dropped = 1'b1;
          end else begin
            cmd.valid = 1'b1;
            cmd.op    = dqc_pkg::OP_PUSH_BACK;
            we        = 1'b1;
            waddr     = stat.back_wr_addr;
            cnt_after = stat.count + dqc_pkg::cnt_t'(1);
            back_next = value;
            if (stat.empty) begin
              front_next = value;
            end
          end
        end
        dqc_pkg::OP_POP_FRONT: begin
          if (!stat.empty) begin
            cmd.valid = 1'b1;
            cmd.op    = dqc_pkg::OP_POP_FRONT;
            pok       = 1'b1;
            popped    = front_word;
            cnt_after = stat.count - dqc_pkg::cnt_t'(1);
            raddr     = stat.front_next_addr;
            if (cnt_after != '0) begin
              re    = 1'b1;
              fetch = 1'b1;
            end
          end
        end
        dqc_pkg::OP_POP_BACK: begin
          if (!stat.empty) begin
            cmd.valid = 1'b1;
            cmd.op    = dqc_pkg::OP_POP_BACK;
            pok       = 1'b1;
            popped    = back_word;
            cnt_after = stat.count - dqc_pkg::cnt_t'(1);
            raddr     = stat.back_next_addr;
            if (cnt_after != '0) begin
              re    = 1'b1;
              fetch = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            pop_value    <= popped;
            pop_ok       <= pok;
            push_dropped <= dropped;
            entry_count  <= dqc_pkg::count_out_t'(cnt_after);
            is_empty     <= (cnt_after == '0);
            if (fetch) begin
              state       <= S_FETCH;
              fetch_front <= (func == dqc_pkg::OP_POP_FRONT);
            end else begin
              done        <= 1'b1;
              front_word  <= front_next;
              back_word   <= back_next;
              front_value <= (cnt_after == '0) ? '1 : front_next;
              back_value  <= (cnt_after == '0) ? '1 : back_next;
            end
          end
        end
        S_FETCH: begin
          // new end word arrives from the ram this cycle
          done  <= 1'b1;
          state <= S_IDLE;
          if (fetch_front) begin
            front_word  <= rword;
            front_value <= rword;
            back_value  <= back_word;
          end else begin
            back_word   <= rword;
            back_value  <= rword;
            front_value <= front_word;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DQC_ASSERT_NEXT(a_fetch_one_cycle, busy, done && !busy)
  `DQC_ASSERT_NEXT(a_request_answered, start && !busy, done || busy)
  `DQC_ASSERT_NOW(a_empty_flag, done, is_empty == (entry_count == '0))
  `DQC_ASSERT_NOW(a_empty_ends, done && is_empty, front_value == '1 && back_value == '1)

endmodule

// File: test/tb_double_ended_queue_core.sv
// self-checking testbench for the deque core: random push/pop traffic against a ring model
module tb_double_ended_queue_core;

  localparam logic [dqc_pkg::FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
  localparam logic [dqc_pkg::FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
  localparam logic [dqc_pkg::FUNC_W-1:0] FUNC_RSVD7 = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam dqc_pkg::word_t WORD_MIN = 32'sh8000_0000;
  localparam dqc_pkg::word_t WORD_MAX = 32'sh7fff_ffff;
  localparam dqc_pkg::word_t WORD_NEG1 = -32'sd1;

  typedef struct {
    logic [dqc_pkg::FUNC_W-1:0] code;
    dqc_pkg::word_t             word;
    bit                         wait_idle;  // hold this request until nothing is outstanding
  } deque_req_t;

  typedef struct {
    dqc_pkg::word_t      pop_value;
    logic                pop_ok;
    logic                push_dropped;
    dqc_pkg::count_out_t entry_count;
    logic                is_empty;
    dqc_pkg::word_t      front_value;
    dqc_pkg::word_t      back_value;
  } deque_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [dqc_pkg::FUNC_W-1:0] func = '0;
  dqc_pkg::word_t value = '0;
  logic busy;
  logic done;
  dqc_pkg::word_t pop_value;
  logic pop_ok;
  logic push_dropped;
  dqc_pkg::count_out_t entry_count;
  logic is_empty;
  dqc_pkg::word_t front_value;
  dqc_pkg::word_t back_value;

  deque_req_t   pending_reqs[$];
  deque_reply_t deque_reply_q[$];

  // ring model of the deque
  dqc_pkg::word_t model_ring [dqc_pkg::DEPTH];
  int model_head = 0;
  int model_tail = 0;
  int model_held = 0;

  int gen_held = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 1;
  int gap_left = 0;

  double_ended_queue_core uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .value        (value),
    .done         (done),
    .pop_value    (pop_value),
    .pop_ok       (pop_ok),
    .push_dropped (push_dropped),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .front_value  (front_value),
    .back_value   (back_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int ring_back(input int idx);
    return (idx + dqc_pkg::DEPTH - 1) % dqc_pkg::DEPTH;
  endfunction

  function automatic int ring_fwd(input int idx);
    return (idx + 1) % dqc_pkg::DEPTH;
  endfunction

  function automatic deque_reply_t apply_deque_request(
      input logic [dqc_pkg::FUNC_W-1:0] code, input dqc_pkg::word_t word);
    deque_reply_t r;
    r.pop_value = WORD_NEG1;
    r.pop_ok = 1'b0;
    r.push_dropped = 1'b0;
    case (code)
      dqc_pkg::OP_PUSH_FRONT: begin
        if (model_held >= dqc_pkg::DEPTH) begin
          r.push_dropped = 1'b1;
        end else begin
          model_head = ring_back(model_head);
          model_ring[model_head] = word;
          model_held++;
        end
      end
      dqc_pkg::OP_PUSH_BACK: begin
        if (model_held >= dqc_pkg::DEPTH) begin
          r.push_dropped = 1'b1;
        end else begin
          model_ring[model_tail] = word;
          model_tail = ring_fwd(model_tail);
          model_held++;
        end
      end
      dqc_pkg::OP_POP_FRONT: begin
        if (model_held != 0) begin
          r.pop_value = model_ring[model_head];
          r.pop_ok = 1'b1;
          model_head = ring_fwd(model_head);
          model_held--;
        end
      end
      dqc_pkg::OP_POP_BACK: begin
        if (model_held != 0) begin
          model_tail = ring_back(model_tail);
          r.pop_value = model_ring[model_tail];
          r.pop_ok = 1'b1;
          model_held--;
        end
      end
      default: ;
    endcase
    r.entry_count = dqc_pkg::count_out_t'(model_held);
    r.is_empty = (model_held == 0);
    r.front_value = (model_held == 0) ? WORD_NEG1 : model_ring[model_head];
    r.back_value = (model_held == 0) ? WORD_NEG1 : model_ring[ring_back(model_tail)];
    return r;
  endfunction

  task automatic add_req(input logic [dqc_pkg::FUNC_W-1:0] code, input dqc_pkg::word_t word,
                         input bit hold);
    deque_req_t q;
    q.code = code;
    q.word = word;
    q.wait_idle = hold;
    pending_reqs = {pending_reqs, q};
    case (code)
      dqc_pkg::OP_PUSH_FRONT, dqc_pkg::OP_PUSH_BACK: if (gen_held < dqc_pkg::DEPTH) gen_held++;
      dqc_pkg::OP_POP_FRONT, dqc_pkg::OP_POP_BACK: if (gen_held > 0) gen_held--;
      default: ;
    endcase
  endtask

  function automatic dqc_pkg::word_t pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return WORD_NEG1;
      3: return '0;
      default: return dqc_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic add_random(input int push_pct, input int pop_pct, input bit hold);
    int roll;
    logic [dqc_pkg::FUNC_W-1:0] code;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      code = $urandom_range(0, 1) ? dqc_pkg::OP_PUSH_FRONT : dqc_pkg::OP_PUSH_BACK;
    end else if (roll < push_pct + pop_pct) begin
      code = $urandom_range(0, 1) ? dqc_pkg::OP_POP_FRONT : dqc_pkg::OP_POP_BACK;
    end else begin
      case ($urandom_range(0, 5))
        0: code = FUNC_RSVD5;
        1: code = FUNC_RSVD6;
        2: code = FUNC_RSVD7;
        default: code = dqc_pkg::OP_NONE;
      endcase
    end
    add_req(code, pick_word(), hold);
  endtask

  // driver: one request per handshake, bursts separated by random gaps
  always @(posedge clk) begin
    deque_req_t nxt;
    logic launch;
    launch = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        deque_reply_q = {deque_reply_q, apply_deque_request(func, value)};
        n_accepted <= n_accepted + 1;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].wait_idle && (start || n_checked != n_accepted))) begin
          nxt = pending_reqs[0];
          pending_reqs.delete(0);
          launch = 1'b1;
          func <= nxt.code;
          value <= nxt.word;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
          end
        end
        start <= launch;
      end
    end
  end

  task automatic check_field(input string what, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // monitor: results arrive in request order and are checked field by field
  always @(posedge clk) begin
    deque_reply_t e;
    if (!rst && done === 1'b1) begin
      if (deque_reply_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got pop_value %0d count %0d",
                 $time, pop_value, entry_count);
        mismatches++;
      end else begin
        e = deque_reply_q[0];
        deque_reply_q.delete(0);
        check_field("pop_value", e.pop_value, pop_value);
        check_field("pop_ok", e.pop_ok, pop_ok);
        check_field("push_dropped", e.push_dropped, push_dropped);
        check_field("entry_count", e.entry_count, entry_count);
        check_field("is_empty", e.is_empty, is_empty);
        check_field("front_value", e.front_value, front_value);
        check_field("back_value", e.back_value, back_value);
        n_checked <= n_checked + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, deque_reply_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    bit first;
    // empty store, extremes, unused codes, both ends down to empty again
    add_req(dqc_pkg::OP_NONE, WORD_MAX, 1'b0);
    add_req(dqc_pkg::OP_POP_FRONT, WORD_NEG1, 1'b0);
    add_req(dqc_pkg::OP_POP_BACK, WORD_MIN, 1'b0);
    add_req(dqc_pkg::OP_PUSH_BACK, WORD_MAX, 1'b0);
    add_req(dqc_pkg::OP_PUSH_FRONT, WORD_MIN, 1'b0);
    add_req(dqc_pkg::OP_NONE, '0, 1'b0);
    add_req(FUNC_RSVD5, 32'sh1234_5678, 1'b0);
    add_req(FUNC_RSVD6, WORD_NEG1, 1'b0);
    add_req(FUNC_RSVD7, WORD_MIN, 1'b0);
    add_req(dqc_pkg::OP_POP_BACK, WORD_NEG1, 1'b0);
    add_req(dqc_pkg::OP_POP_FRONT, WORD_MAX, 1'b0);
    add_req(dqc_pkg::OP_PUSH_FRONT, WORD_NEG1, 1'b0);
    add_req(dqc_pkg::OP_PUSH_BACK, '0, 1'b0);
    add_req(dqc_pkg::OP_PUSH_FRONT, 32'sd1, 1'b0);
    add_req(dqc_pkg::OP_POP_FRONT, '0, 1'b0);
    add_req(dqc_pkg::OP_POP_BACK, '0, 1'b0);
    add_req(dqc_pkg::OP_POP_BACK, '0, 1'b0);
    add_req(dqc_pkg::OP_POP_FRONT, '0, 1'b0);
    add_req(dqc_pkg::OP_PUSH_BACK, 32'sh5555_5555, 1'b0);
    add_req(dqc_pkg::OP_PUSH_BACK, 32'shaaaa_aaaa, 1'b0);
    add_req(dqc_pkg::OP_POP_FRONT, '0, 1'b0);
    add_req(dqc_pkg::OP_POP_FRONT, '0, 1'b0);
    // shallow random walk, pops often hit the empty store
    repeat (100) add_random(45, 45, 1'b0);
    // fill to full with the sender paused first until all results are in
    first = 1'b1;
    while (gen_held < dqc_pkg::DEPTH) begin
      add_random(92, 4, first);
      first = 1'b0;
    end
    // churn at full: refused pushes
    repeat (40) add_random(60, 30, 1'b0);
    repeat (150) add_random(10, 85, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending_reqs.size() != 0 || start || n_checked != n_accepted) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && deque_reply_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/dqc_pkg.sv
src/dqc_ram.sv
src/dqc_ptr.sv
src/double_ended_queue_core.sv
test/tb_double_ended_queue_core.sv
